FILE: rtl/vcpm_pkg.sv
// vcpm_pkg: shared types, codes and the phrase table of the voice command phrase matcher.
// Used by rtl/voice_command_phrase_matcher.sv; depends on nothing else.
package vcpm_pkg;

  localparam int TEXT_CAPACITY_DEF = 256;
  localparam int WIN_BYTES         = 12;
  localparam int GROUP_COUNT       = 6;
  localparam int PHRASE_COUNT      = 27;

  localparam logic [15:0] DUP_WINDOW_RESET = 16'd1500;

  // Operation codes of an input item.
  localparam logic OP_TEXT    = 1'b0;
  localparam logic OP_SESSION = 1'b1;

  // Command codes.
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_LIGHT_OFF = 3'd1;
  localparam logic [2:0] CMD_LIGHT_ON  = 3'd2;
  localparam logic [2:0] CMD_SIT       = 3'd3;
  localparam logic [2:0] CMD_STAND     = 3'd4;
  localparam logic [2:0] CMD_SHAKE     = 3'd5;

  // Outcome codes.
  localparam logic [1:0] OUTC_NONE   = 2'd0;
  localparam logic [1:0] OUTC_DUP    = 2'd1;
  localparam logic [1:0] OUTC_ISSUED = 2'd2;

  // Group indexes, also the bit positions of the hit flags.
  localparam logic [2:0] GRP_NEG   = 3'd0;
  localparam logic [2:0] GRP_OFF   = 3'd1;
  localparam logic [2:0] GRP_ON    = 3'd2;
  localparam logic [2:0] GRP_SIT   = 3'd3;
  localparam logic [2:0] GRP_STAND = 3'd4;
  localparam logic [2:0] GRP_SHAKE = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command_code;
    logic [1:0] outcome;
  } out_item_t;

  typedef logic [WIN_BYTES-1:0][7:0] window_t;

  // Phrases are right-aligned: the last byte of a phrase sits in the lowest byte.
  localparam logic [WIN_BYTES*8-1:0] PHRASE_BYTES [PHRASE_COUNT] = '{
    96'hE4B88DE8A681,
    96'hE588AB,
    96'hE4B88DE794A8,
    96'hE585B3E781AF,
    96'hE585B3E997ADE781AF,
    96'hE781AFE585B3E68E89,
    96'hE585B3E4B880E4B88BE781AF,
    96'hE78684E781AF,
    96'h4C494748545F4F4646,
    96'hE5BC80E781AF,
    96'hE68993E5BC80E781AF,
    96'hE781AFE68993E5BC80,
    96'hE5BC80E4B880E4B88BE781AF,
    96'hE4BAAEE781AF,
    96'h4C494748545F4F4E,
    96'hE59D90E4B88B,
    96'hE8B6B4E4B88B,
    96'hE694B6E8B5B7,
    96'h534954,
    96'hE7AB99E7AB8B,
    96'hE7AB99E8B5B7E69DA5,
    96'hE8B5B7E8BAAB,
    96'h5354414E44,
    96'hE69187E69187E5A4B4,
    96'hE69187E4B880E4B88BE5A4B4,
    96'hE69187E5A4B4,
    96'h534841 << 56 | 96'h4B455F48454144
  };

  localparam logic [3:0] PHRASE_LEN [PHRASE_COUNT] = '{
    4'd6, 4'd3, 4'd6,
    4'd6, 4'd9, 4'd9, 4'd12, 4'd6, 4'd9,
    4'd6, 4'd9, 4'd9, 4'd12, 4'd6, 4'd8,
    4'd6, 4'd6, 4'd6, 4'd3,
    4'd6, 4'd9, 4'd6, 4'd5,
    4'd9, 4'd12, 4'd6, 4'd10
  };

  localparam logic [2:0] PHRASE_GROUP [PHRASE_COUNT] = '{
    GRP_NEG, GRP_NEG, GRP_NEG,
    GRP_OFF, GRP_OFF, GRP_OFF, GRP_OFF, GRP_OFF, GRP_OFF,
    GRP_ON, GRP_ON, GRP_ON, GRP_ON, GRP_ON, GRP_ON,
    GRP_SIT, GRP_SIT, GRP_SIT, GRP_SIT,
    GRP_STAND, GRP_STAND, GRP_STAND, GRP_STAND,
    GRP_SHAKE, GRP_SHAKE, GRP_SHAKE, GRP_SHAKE
  };

endpackage

FILE: rtl/voice_command_phrase_matcher.sv
// voice_command_phrase_matcher: phrase spotting over a UTF-8 byte stream with duplicate
// suppression. Depends on rtl/vcpm_pkg.sv.
//
// Timing: a transferred text byte is registered into the match stage and matched there; the
// result of a last byte is registered into out_item. Throughput: one item per cycle but for
// output stalls, set by the single match stage and the one write port of the text store.
// Reset (rst_n, synchronous, active low) clears the control state and sets the duplicate
// window to 1500 ms; the text store is not cleared, since a stored length of zero marks it
// empty and no entry at or beyond the stored length is used in the comparison.
module voice_command_phrase_matcher #(
  parameter int TEXT_CAPACITY = vcpm_pkg::TEXT_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  vcpm_pkg::in_item_t  in_item,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output vcpm_pkg::out_item_t out_item,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import vcpm_pkg::*;

  // Address width of one text bank and width of a byte count (which may reach the capacity).
  localparam int AW = $clog2(TEXT_CAPACITY);
  localparam int CW = $clog2(TEXT_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(TEXT_CAPACITY);

  // ---------------------------------------------------------------------------------------
  // Front end. The byte count only depends on the operation and last-byte flags, so it is
  // kept at the input side. That lets the text store be read for the byte at the moment of
  // its transfer, with the data ready when the byte reaches the match stage.
  // ---------------------------------------------------------------------------------------
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          in_xfer;
  logic [AW-1:0] rd_idx;

  // Match stage register: the item, its byte position and the stored bytes at that position.
  logic          stg_valid_r;
  in_item_t      stg_item_r;
  logic [CW-1:0] stg_cnt_r;
  logic [7:0]    rd0_r, rd1_r;

  // Persistent matcher state.
  window_t          win_r, win_nxt;
  logic [GROUP_COUNT-1:0] hits_r, hits_nxt;
  logic             bank_sel_r, bank_sel_nxt;
  logic [CW-1:0]    stored_len_r, stored_len_nxt;
  logic             still_eq_r, still_eq_nxt;
  logic [31:0]      stored_time_r, stored_time_nxt;
  logic [15:0]      dup_window_r;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Two banks of text: the one selected by bank_sel_r holds the last issued text, the other
  // collects the text now arriving. An issued text simply flips the selection.
  logic [7:0] bank_mem [2][TEXT_CAPACITY];

  // Match stage signals.
  logic                   stg_hold;
  logic                   stg_adv;
  logic                   stg_text;
  logic                   stg_in_cap;
  logic                   stg_result;
  logic [CW-1:0]          len_after;
  window_t                win_shift;
  logic [GROUP_COUNT-1:0] match_hits;
  logic [GROUP_COUNT-1:0] hits_all;
  logic                   eq_after;
  logic [7:0]             stored_byte;
  logic [2:0]             cmd;
  logic [31:0]            age;
  logic                   mem_we;
  logic [AW-1:0]          wr_idx;
  logic                   wr_bank;

  // The match stage can only hold back when it has a result for a full, stalled output.
  assign stg_result = stg_valid_r && (stg_item_r.operation == OP_TEXT) && stg_item_r.last_byte;
  assign stg_hold   = stg_result && out_valid_r && out_stall;
  assign stg_adv    = stg_valid_r && !stg_hold;
  assign in_stall   = stg_valid_r && stg_hold;
  assign in_xfer    = in_valid && !in_stall;

  assign rd_idx = (cnt_r < CAP) ? cnt_r[AW-1:0] : '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      if (in_item.operation == OP_SESSION || in_item.last_byte) begin
        cnt_nxt = '0;
      end else if (cnt_r < CAP) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Text store: one write port from the match stage, one read port per bank at the input
  // transfer. A write landing on the very entry read at the same edge is forwarded, which
  // happens when a one-byte text is issued and the next text begins straight after it.
  // ---------------------------------------------------------------------------------------
  assign stg_text   = stg_item_r.operation == OP_TEXT;
  assign stg_in_cap = stg_cnt_r < CAP;
  assign mem_we     = stg_adv && stg_text && stg_in_cap;
  assign wr_idx     = stg_cnt_r[AW-1:0];
  assign wr_bank    = ~bank_sel_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bank_mem[wr_bank][wr_idx] <= stg_item_r.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (mem_we && wr_bank == 1'b0 && wr_idx == rd_idx) begin
        rd0_r <= stg_item_r.text_byte;
      end else begin
        rd0_r <= bank_mem[0][rd_idx];
      end
      if (mem_we && wr_bank == 1'b1 && wr_idx == rd_idx) begin
        rd1_r <= stg_item_r.text_byte;
      end else begin
        rd1_r <= bank_mem[1][rd_idx];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Match stage. The window moves by one byte, every phrase is compared against its newest
  // bytes, and the text is compared with the stored one at the same position.
  // ---------------------------------------------------------------------------------------
  assign win_shift   = {win_r[WIN_BYTES-2:0], stg_item_r.text_byte};
  assign stored_byte = bank_sel_r ? rd1_r : rd0_r;

  always_comb begin
    logic hit;
    match_hits = '0;
    for (int p = 0; p < PHRASE_COUNT; p++) begin
      hit = 1'b1;
      for (int i = 0; i < WIN_BYTES; i++) begin
        if (i < int'(PHRASE_LEN[p]) && win_shift[i] != PHRASE_BYTES[p][8*i +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match_hits[PHRASE_GROUP[p]] = 1'b1;
      end
    end
  end

  // Bytes beyond the capacity leave window, hits and the comparison untouched.
  assign hits_all  = stg_in_cap ? (hits_r | match_hits) : hits_r;
  assign eq_after  = stg_in_cap ? (still_eq_r && (stg_cnt_r < stored_len_r) &&
                                   (stored_byte == stg_item_r.text_byte))
                                : still_eq_r;
  assign len_after = stg_in_cap ? stg_cnt_r + 1'b1 : stg_cnt_r;
  assign age       = stg_item_r.time_ms - stored_time_r;

  // A negation anywhere in the text cancels it; otherwise the lowest group with a hit wins.
  always_comb begin
    if (hits_all[GRP_NEG]) begin
      cmd = CMD_NONE;
    end else if (hits_all[GRP_OFF]) begin
      cmd = CMD_LIGHT_OFF;
    end else if (hits_all[GRP_ON]) begin
      cmd = CMD_LIGHT_ON;
    end else if (hits_all[GRP_SIT]) begin
      cmd = CMD_SIT;
    end else if (hits_all[GRP_STAND]) begin
      cmd = CMD_STAND;
    end else if (hits_all[GRP_SHAKE]) begin
      cmd = CMD_SHAKE;
    end else begin
      cmd = CMD_NONE;
    end
  end

  always_comb begin
    win_nxt         = win_r;
    hits_nxt        = hits_r;
    still_eq_nxt    = still_eq_r;
    bank_sel_nxt    = bank_sel_r;
    stored_len_nxt  = stored_len_r;
    stored_time_nxt = stored_time_r;
    out_item_nxt    = out_item_r;
    // A waiting result leaves once the far side takes it.
    out_valid_nxt   = out_valid_r && out_stall;

    if (stg_adv) begin
      if (!stg_text) begin
        // Session start forgets the issued text and any text half received.
        win_nxt         = '0;
        hits_nxt        = '0;
        still_eq_nxt    = 1'b1;
        stored_len_nxt  = '0;
        stored_time_nxt = '0;
      end else if (stg_item_r.last_byte) begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.command_code = cmd;
        if (cmd == CMD_NONE) begin
          out_item_nxt.outcome = OUTC_NONE;
        end else if (eq_after && len_after == stored_len_r &&
                     age < {16'b0, dup_window_r}) begin
          out_item_nxt.outcome = OUTC_DUP;
        end else begin
          out_item_nxt.outcome = OUTC_ISSUED;
          bank_sel_nxt         = ~bank_sel_r;
          stored_len_nxt       = len_after;
          stored_time_nxt      = stg_item_r.time_ms;
        end
        win_nxt      = '0;
        hits_nxt     = '0;
        still_eq_nxt = 1'b1;
      end else if (stg_in_cap) begin
        win_nxt      = win_shift;
        hits_nxt     = hits_all;
        still_eq_nxt = eq_after;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      stg_valid_r   <= 1'b0;
      win_r         <= '0;
      hits_r        <= '0;
      still_eq_r    <= 1'b1;
      bank_sel_r    <= 1'b0;
      stored_len_r  <= '0;
      stored_time_r <= '0;
      out_valid_r   <= 1'b0;
      dup_window_r  <= DUP_WINDOW_RESET;
    end else begin
      cnt_r         <= cnt_nxt;
      if (!in_stall) begin
        stg_valid_r <= in_valid;
      end
      win_r         <= win_nxt;
      hits_r        <= hits_nxt;
      still_eq_r    <= still_eq_nxt;
      bank_sel_r    <= bank_sel_nxt;
      stored_len_r  <= stored_len_nxt;
      stored_time_r <= stored_time_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        dup_window_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_item_r <= in_item;
      stg_cnt_r  <= cnt_r;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: test/testbench.sv
// testbench: self-checking bench for the voice command phrase matcher, top-level test module.
// Depends on rtl/vcpm_pkg.sv for the item types and codes, and on the block itself;
// it holds its own copy of the phrase table and its own prediction of every result.

module testbench;
  import vcpm_pkg::*;

  // The text store is sized the same on both sides, so that capacity overflow is
  // predicted at the same byte as the block sees it.
  localparam int TEXT_CAP    = 256;
  localparam int KEY_COUNT   = 27;
  localparam int TAIL_BYTES  = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_GOAL  = 300;

  // Key phrases, right-aligned: the final byte of a phrase is the lowest byte.
  localparam logic [95:0] KEY_BYTES [KEY_COUNT] = '{
    96'hE4B88DE8A681, 96'hE588AB, 96'hE4B88DE794A8,
    96'hE585B3E781AF, 96'hE585B3E997ADE781AF, 96'hE781AFE585B3E68E89,
    96'hE585B3E4B880E4B88BE781AF, 96'hE78684E781AF, 96'h4C494748545F4F4646,
    96'hE5BC80E781AF, 96'hE68993E5BC80E781AF, 96'hE781AFE68993E5BC80,
    96'hE5BC80E4B880E4B88BE781AF, 96'hE4BAAEE781AF, 96'h4C494748545F4F4E,
    96'hE59D90E4B88B, 96'hE8B6B4E4B88B, 96'hE694B6E8B5B7, 96'h534954,
    96'hE7AB99E7AB8B, 96'hE7AB99E8B5B7E69DA5, 96'hE8B5B7E8BAAB, 96'h5354414E44,
    96'hE69187E69187E5A4B4, 96'hE69187E4B880E4B88BE5A4B4, 96'hE69187E5A4B4,
    96'h5348414B455F48454144
  };

  localparam int KEY_LEN [KEY_COUNT] = '{
    6, 3, 6,
    6, 9, 9, 12, 6, 9,
    6, 9, 9, 12, 6, 8,
    6, 6, 6, 3,
    6, 9, 6, 5,
    9, 12, 6, 10
  };

  localparam logic [2:0] KEY_GROUP [KEY_COUNT] = '{
    GRP_NEG, GRP_NEG, GRP_NEG,
    GRP_OFF, GRP_OFF, GRP_OFF, GRP_OFF, GRP_OFF, GRP_OFF,
    GRP_ON, GRP_ON, GRP_ON, GRP_ON, GRP_ON, GRP_ON,
    GRP_SIT, GRP_SIT, GRP_SIT, GRP_SIT,
    GRP_STAND, GRP_STAND, GRP_STAND, GRP_STAND,
    GRP_SHAKE, GRP_SHAKE, GRP_SHAKE, GRP_SHAKE
  };

  // Command code announced for each group; the negation group announces nothing.
  localparam logic [2:0] GROUP_TO_CMD [6] = '{
    CMD_NONE, CMD_LIGHT_OFF, CMD_LIGHT_ON, CMD_SIT, CMD_STAND, CMD_SHAKE
  };

  // Index of the first key that is not a negation, and of the plain "SIT" key.
  localparam int FIRST_CMD_KEY = 3;
  localparam int SIT_KEY       = 18;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_item     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int queued_total   = 0;

  in_item_t   pending_items [$];
  out_item_t  expected_results [$];
  logic [7:0] draft [$];
  logic [7:0] prev_text [$];
  logic [31:0] clock_ms = 32'h0000_04DC;

  // Predicted state of the block.
  logic [15:0] dup_window = DUP_WINDOW_RESET;
  logic [7:0]  recent [TAIL_BYTES];
  logic [5:0]  hits;
  logic [7:0]  text_store [2*TEXT_CAP];
  int          bank_sel;
  int          byte_count;
  int          stored_len;
  logic        same_so_far;
  logic [31:0] stored_time;

  voice_command_phrase_matcher #(.TEXT_CAPACITY(TEXT_CAP)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The cycle counter doubles as the watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Forget the text under way, as at the end of a text or at a session start.
  function automatic void clear_text();
    foreach (recent[k]) recent[k] = 8'h00;
    hits        = '0;
    byte_count  = 0;
    same_so_far = 1'b1;
  endfunction

  // One byte enters the tail window and the store, is compared against the remembered
  // text, and every key phrase is tried against the newest bytes of the window.
  function automatic void take_byte(input logic [7:0] b);
    logic [95:0] tail;
    logic [95:0] mask;
    tail = '0;
    for (int k = 0; k < TAIL_BYTES - 1; k++) recent[k] = recent[k+1];
    recent[TAIL_BYTES-1] = b;
    text_store[(1 - bank_sel) * TEXT_CAP + byte_count] = b;
    if (byte_count < stored_len) begin
      if (text_store[bank_sel * TEXT_CAP + byte_count] != b) same_so_far = 1'b0;
    end else begin
      same_so_far = 1'b0;
    end
    for (int k = 0; k < TAIL_BYTES; k++) tail = {tail[87:0], recent[k]};
    for (int p = 0; p < KEY_COUNT; p++) begin
      mask = {96{1'b1}} >> (96 - 8 * KEY_LEN[p]);
      if (((tail ^ KEY_BYTES[p]) & mask) == '0) hits[KEY_GROUP[p]] = 1'b1;
    end
    byte_count++;
  endfunction

  // Works out the effect of one accepted transfer and queues its result, if any.
  function automatic void predict_item(input in_item_t it);
    logic [2:0]  cmd;
    logic [31:0] age;
    out_item_t   res;
    if (it.operation == OP_SESSION) begin
      stored_len  = 0;
      stored_time = '0;
      clear_text();
    end else begin
      // Bytes beyond the capacity are dropped, but a last byte there still closes the text.
      if (byte_count < TEXT_CAP) take_byte(it.text_byte);
      if (it.last_byte) begin
        cmd = CMD_NONE;
        // Walk from the lowest priority upwards, so that the highest-priority hit wins.
        if (!hits[GRP_NEG]) begin
          for (int g = 5; g >= 1; g--) if (hits[g]) cmd = GROUP_TO_CMD[g];
        end
        age = it.time_ms - stored_time;
        res.command_code = cmd;
        if (cmd == CMD_NONE) begin
          res.outcome = OUTC_NONE;
        end else if (same_so_far && byte_count == stored_len && age < {16'h0, dup_window}) begin
          res.outcome = OUTC_DUP;
        end else begin
          res.outcome = OUTC_ISSUED;
          bank_sel    = 1 - bank_sel;
          stored_len  = byte_count;
          stored_time = it.time_ms;
        end
        expected_results.push_back(res);
        clear_text();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------------------

  // Idles with a chance of 30 in a hundred, except in a long calm stretch at the end of each
  // period of the cycle count, where both sides run flat out.
  function automatic bit take_break();
    if ((cycle_count % 5000) >= 3500) return 1'b0;
    return $urandom_range(0, 99) < 30;
  endfunction

  // The driver predicts each transfer at the edge where it happens, then offers the next
  // pending item once the current one has gone. A stalled item is held unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_item(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !take_break()) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // The monitor checks each result transfer against the oldest prediction.
  out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d/%0d",
                                    out_item.command_code, out_item.outcome));
        end else begin
          want = expected_results.pop_front();
          if (out_item.command_code !== want.command_code)
            report_mismatch($sformatf("command_code %0d, expected %0d",
                                      out_item.command_code, want.command_code));
          if (out_item.outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, expected %0d",
                                      out_item.outcome, want.outcome));
        end
      end
      out_stall <= take_break();
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  task automatic add_noise(input int n);
    repeat (n) draft.push_back(8'($urandom));
  endtask

  task automatic add_key(input int p);
    for (int k = KEY_LEN[p] - 1; k >= 0; k--) draft.push_back(KEY_BYTES[p][8*k +: 8]);
  endtask

  // Queues the draft as text bytes. Time on the inner bytes is ignored, so it is random.
  task automatic queue_text(input logic [31:0] at_ms, input bit closes);
    in_item_t it;
    foreach (draft[i]) begin
      it.operation = OP_TEXT;
      it.text_byte = draft[i];
      it.last_byte = closes && (i == draft.size() - 1);
      it.time_ms   = it.last_byte ? at_ms : $urandom;
      pending_items.push_back(it);
      queued_total++;
    end
    if (closes) prev_text = draft;
  endtask

  // A session start ignores its byte and last flag, so both are random.
  task automatic queue_session();
    in_item_t it;
    it.operation = OP_SESSION;
    it.text_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.time_ms   = $urandom;
    pending_items.push_back(it);
    queued_total++;
  endtask

  // Advances the stimulus clock, often to just inside or just on the duplicate window.
  function automatic logic [31:0] next_stamp();
    case ($urandom_range(0, 3))
      0:       clock_ms += $urandom;
      1:       clock_ms += (dup_window == 16'h0) ? 32'h0 : 32'(dup_window) - 32'h1;
      2:       clock_ms += 32'(dup_window);
      default: clock_ms += $urandom_range(0, dup_window);
    endcase
    return clock_ms;
  endfunction

  // Waits until every item has been transferred and every result has come back, then
  // leaves room for a trailing session start to settle inside the block.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only ever called with the block idle.
  task automatic set_window(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    dup_window  = value;
  endtask

  task automatic run_phase(input logic [15:0] window, input bit long_texts);
    int start;
    int kind;
    int p;
    int cut;
    start = queued_total;
    set_window(window);
    if (long_texts) begin
      // A command that begins below the capacity and may cross it, then the same text again with a change
      // beyond the capacity only, which still counts as the same text.
      draft.delete();
      add_noise($urandom_range(248, 252));
      add_key($urandom_range(FIRST_CMD_KEY, KEY_COUNT - 1));
      add_noise($urandom_range(6, 12));
      queue_text(next_stamp(), 1'b1);
      draft = prev_text;
      draft[draft.size() - 1] = draft[draft.size() - 1] ^ 8'h5A;
      queue_text(clock_ms + $urandom_range(0, 1000), 1'b1);
    end
    while (queued_total - start < PHASE_GOAL) begin
      draft.delete();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        add_noise($urandom_range(0, 4));
        add_key($urandom_range(0, KEY_COUNT - 1));
        if ($urandom_range(0, 3) == 0) add_key($urandom_range(0, KEY_COUNT - 1));
        add_noise($urandom_range(0, 3));
        queue_text(next_stamp(), 1'b1);
      end else if (kind < 60) begin
        // Repeat the previous text, the main source of duplicates.
        if (prev_text.size() != 0 && prev_text.size() <= 32) draft = prev_text;
        else add_key(SIT_KEY);
        queue_text(next_stamp(), 1'b1);
      end else if (kind < 70) begin
        p = $urandom_range(FIRST_CMD_KEY, KEY_COUNT - 1);
        if ($urandom_range(0, 1)) begin
          add_key($urandom_range(0, FIRST_CMD_KEY - 1));
          add_noise($urandom_range(0, 2));
          add_key(p);
        end else begin
          add_key(p);
          add_noise($urandom_range(0, 2));
          add_key($urandom_range(0, FIRST_CMD_KEY - 1));
        end
        queue_text(next_stamp(), 1'b1);
      end else if (kind < 78) begin
        // A phrase broken by a stray byte in the middle.
        p   = $urandom_range(0, KEY_COUNT - 1);
        cut = $urandom_range(1, KEY_LEN[p] - 1);
        for (int k = KEY_LEN[p] - 1; k >= 0; k--) begin
          if (k == KEY_LEN[p] - 1 - cut) add_noise(1);
          draft.push_back(KEY_BYTES[p][8*k +: 8]);
        end
        queue_text(next_stamp(), 1'b1);
      end else if (kind < 88) begin
        add_noise($urandom_range(1, 12));
        queue_text(next_stamp(), 1'b1);
      end else if (kind < 94) begin
        queue_session();
      end else begin
        // A text abandoned part way by a session start.
        if ($urandom_range(0, 1)) add_key($urandom_range(0, KEY_COUNT - 1));
        add_noise($urandom_range(1, 6));
        queue_text(next_stamp(), 1'b0);
        queue_session();
      end
    end
    drain();
  endtask

  initial begin
    bank_sel    = 0;
    stored_len  = 0;
    stored_time = '0;
    clear_text();

    // Directed texts, under the reset window of 1500 ms. The first pair straddles the
    // wrap of the millisecond counter and must be seen as a duplicate; the third lands
    // exactly on the window edge and is issued again.
    draft.delete(); add_key(SIT_KEY); queue_text(32'hFFFF_FF00, 1'b1);
    draft.delete(); add_key(SIT_KEY); queue_text(32'h0000_0100, 1'b1);
    draft.delete(); add_key(SIT_KEY); queue_text(32'h0000_04DC, 1'b1);
    // A negation overrides the command that follows it.
    draft.delete(); add_key(1); add_key(SIT_KEY); queue_text(32'h0000_04DD, 1'b1);
    // A lone zero byte and a lone all-ones byte, each a complete text with no command.
    draft.delete(); draft.push_back(8'h00); queue_text(32'hFFFF_FFFF, 1'b1);
    // After a session start the same text at the same time is issued afresh.
    queue_session();
    draft.delete(); add_key(SIT_KEY); queue_text(32'h0000_04DC, 1'b1);
    draft.delete(); draft.push_back(8'hFF); queue_text(32'h0000_0000, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // Random phases, each under its own duplicate window, the extremes among them.
    run_phase(16'd0, 1'b0);
    run_phase(16'hFFFF, 1'b1);
    run_phase(16'd1, 1'b0);
    run_phase(16'($urandom_range(2, 65534)), 1'b0);
    run_phase(DUP_WINDOW_RESET, 1'b0);

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
